@@ rtl/spui_pkg.sv @@
// Package for the sorted pool with unique insert.
// Holds command and outcome codes, register indexes and the cell chain struct.
package spui_pkg;

  localparam int WORTH_W     = 32;
  localparam int GENE_PORT_W = 64;
  localparam int RIDX_W      = 6;
  localparam int RANK_W      = 6;
  localparam int OUTCOME_W   = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int PSIZE_W     = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_WORSE     = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_DUPLICATE = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_READ      = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SIZE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIQUE_MODE        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_WORTH_ONLY = 2'd2;

  localparam logic [PSIZE_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

  // Passed from cell to cell: seen = insert position lies further up the row,
  // run = every cell from the insert position up to here has equal worth.
  typedef struct packed {
    logic seen;
    logic run;
  } spui_chain_t;

endpackage

@@ rtl/spui_if.sv @@
// Handshake channels for the sorted pool: command in, result out.
// Depends on spui_pkg for field widths.
interface spui_cmd_if import spui_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [WORTH_W-1:0]   new_worth;
  logic        [GENE_PORT_W-1:0] gene_bits;
  logic        [RIDX_W-1:0]    read_index;

  modport source (output valid, kind, new_worth, gene_bits, read_index, input ready);
  modport sink   (input valid, kind, new_worth, gene_bits, read_index, output ready);
endinterface

interface spui_res_if import spui_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic        [OUTCOME_W-1:0] outcome;
  logic        [RANK_W-1:0]    insert_rank;
  logic signed [WORTH_W-1:0]   entry_worth;
  logic        [GENE_PORT_W-1:0] entry_gene;
  logic                        entry_valid;

  modport source (output valid, outcome, insert_rank, entry_worth, entry_gene, entry_valid,
                  input ready);
  modport sink   (input valid, outcome, insert_rank, entry_worth, entry_gene, entry_valid,
                  output ready);
endinterface

@@ rtl/sorted_pool_unique_insert_top.sv @@
// Top level of the sorted pool with unique insert.
// Depends on spui_pkg, spui_if and spui_cell.
//
// Keeps a pool of POOL_DEPTH entries (signed Q16.16 worth, gene bits, valid)
// sorted from best (smallest worth) to worst, with empty entries last. An
// insert command is dropped when worse than the last active entry, rejected
// as a duplicate in unique mode, or placed ahead of equal-worth entries with
// the rest shifted down one slot and the last active entry lost. A read
// command returns one stored entry. The input transfer captures the command;
// the result is then registered through the states S_CMP, in which every cell
// compares its slot with the candidate in parallel, and S_UPD, in which the
// decision ripples down the row of cells and the shift is done. A new command
// is taken once the sequencer is back in idle, the cycle after the result is
// written, so the block takes no new command while one is in flight; a
// stalled result holds the chain. The user must write configuration only
// while idle; the block itself does not enforce it.
module sorted_pool_unique_insert_top import spui_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int GENE_BITS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  spui_cmd_if.sink               cmd,
  spui_res_if.source             res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int NW    = (CNT_W > PSIZE_W) ? CNT_W : PSIZE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state;

  // configuration registers
  logic [PSIZE_W-1:0] active_size;
  logic               unique_mode;
  logic               compare_worth_only;

  // captured command
  logic                      cand_kind;
  logic signed [WORTH_W-1:0] cand_worth;
  logic [GENE_BITS-1:0]      cand_gene;
  logic [RIDX_W-1:0]         cand_idx;

  // result register
  logic                        out_valid;
  logic [OUTCOME_W-1:0]        out_outcome;
  logic [RANK_W-1:0]           out_rank;
  logic signed [WORTH_W-1:0]   out_worth;
  logic [GENE_PORT_W-1:0]      out_gene;
  logic                        out_entry_valid;

  // cell row
  logic signed [WORTH_W-1:0] cell_worth [POOL_DEPTH];
  logic [GENE_BITS-1:0]      cell_gene  [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]     cell_valid;
  logic [POOL_DEPTH-1:0]     cell_lt;
  logic [POOL_DEPTH-1:0]     cell_rank;
  logic [POOL_DEPTH-1:0]     cell_dup;
  logic [POOL_DEPTH-1:0]     active_mask;
  logic [POOL_DEPTH-1:0]     last_mask;
  spui_chain_t               chain [POOL_DEPTH+1];

  logic [NW-1:0]             n_act;
  logic [NW-1:0]             psize_ext;
  logic                      cmp_en;
  logic                      upd_en;
  logic                      out_free;
  logic                      worse;
  logic                      dup_any;
  logic [RANK_W-1:0]         rank;
  logic signed [WORTH_W-1:0] rd_worth;
  logic [GENE_BITS-1:0]      rd_gene;
  logic                      rd_valid;

  // Clamp the active count: zero acts as one, oversize acts as full depth.
  always_comb begin
    psize_ext = NW'(active_size);
    if (psize_ext == '0) begin
      n_act = NW'(1);
    end else if (psize_ext > NW'(POOL_DEPTH)) begin
      n_act = NW'(POOL_DEPTH);
    end else begin
      n_act = psize_ext;
    end
  end

  assign chain[0] = '{seen: 1'b0, run: 1'b0};

  genvar g;
  generate
    for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
      logic signed [WORTH_W-1:0] left_worth;
      logic [GENE_BITS-1:0]      left_gene;
      logic                      left_valid;

      if (g == 0) begin : g_head
        assign left_worth = '0;
        assign left_gene  = '0;
        assign left_valid = 1'b0;
      end else begin : g_body
        assign left_worth = cell_worth[g-1];
        assign left_gene  = cell_gene[g-1];
        assign left_valid = cell_valid[g-1];
      end

      assign active_mask[g] = NW'(g) < n_act;
      assign last_mask[g]   = NW'(g + 1) == n_act;

      spui_cell #(
        .GENE_BITS (GENE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmp_en     (cmp_en),
        .upd_en     (upd_en),
        .active     (active_mask[g]),
        .worth_only (compare_worth_only),
        .cand_worth (cand_worth),
        .cand_gene  (cand_gene),
        .left_worth (left_worth),
        .left_gene  (left_gene),
        .left_valid (left_valid),
        .chain_in   (chain[g]),
        .chain_out  (chain[g+1]),
        .worth      (cell_worth[g]),
        .gene       (cell_gene[g]),
        .valid      (cell_valid[g]),
        .lt         (cell_lt[g]),
        .is_rank    (cell_rank[g]),
        .dup        (cell_dup[g])
      );
    end
  endgenerate

  // Decision over the row: drop when the last active slot is better,
  // reject when a duplicate sits in the equal-worth run at the insert point.
  always_comb begin
    worse   = |(cell_lt & last_mask);
    dup_any = unique_mode && (|cell_dup);
    rank    = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (cell_rank[i]) begin
        rank = rank | RANK_W'(i);
      end
    end
  end

  // Read select; an index past the depth reads as zero.
  always_comb begin
    rd_worth = '0;
    rd_gene  = '0;
    rd_valid = 1'b0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (32'(cand_idx) == i) begin
        rd_worth = cell_worth[i];
        rd_gene  = cell_gene[i];
        rd_valid = cell_valid[i];
      end
    end
  end

  assign out_free = !out_valid || res.ready;
  assign cmp_en   = (state == S_CMP);
  assign upd_en   = (state == S_UPD) && out_free && (cand_kind == KIND_INSERT)
                    && !worse && !dup_any;
  assign cmd.ready = (state == S_IDLE);

  assign res.valid       = out_valid;
  assign res.outcome     = out_outcome;
  assign res.insert_rank = out_rank;
  assign res.entry_worth = out_worth;
  assign res.entry_gene  = out_gene;
  assign res.entry_valid = out_entry_valid;

  // configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size        <= ACTIVE_SIZE_RESET;
      unique_mode        <= 1'b1;
      compare_worth_only <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_SIZE:        active_size        <= cfg_data;
        REG_UNIQUE_MODE:        unique_mode        <= cfg_data[0];
        REG_COMPARE_WORTH_ONLY: compare_worth_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer: capture, compare, resolve and write the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise on a new result, drop once the held one transfers
      if (state == S_UPD && out_free) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          // hold until the result register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      cand_kind  <= cmd.kind;
      cand_worth <= cmd.new_worth;
      cand_gene  <= cmd.gene_bits[GENE_BITS-1:0];
      cand_idx   <= cmd.read_index;
    end
    if (state == S_UPD && out_free) begin
      if (cand_kind == KIND_READ) begin
        out_outcome     <= OUTCOME_READ;
        out_rank        <= '0;
        out_worth       <= rd_worth;
        out_gene        <= GENE_PORT_W'(rd_gene);
        out_entry_valid <= rd_valid;
      end else begin
        out_worth       <= '0;
        out_gene        <= '0;
        out_entry_valid <= 1'b0;
        if (worse) begin
          out_outcome <= OUTCOME_WORSE;
          out_rank    <= '0;
        end else if (dup_any) begin
          out_outcome <= OUTCOME_DUPLICATE;
          out_rank    <= '0;
        end else begin
          out_outcome <= OUTCOME_INSERTED;
          out_rank    <= rank;
        end
      end
    end
  end

endmodule

@@ rtl/spui_cell.sv @@
// One pool slot of the sorted pool: stored entry, compare flags, chain logic.
// Depends on spui_pkg for widths and the chain struct.
module spui_cell import spui_pkg::*; #(
  parameter int GENE_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmp_en,
  input  logic                      upd_en,
  input  logic                      active,
  input  logic                      worth_only,
  input  logic signed [WORTH_W-1:0] cand_worth,
  input  logic [GENE_BITS-1:0]      cand_gene,
  input  logic signed [WORTH_W-1:0] left_worth,
  input  logic [GENE_BITS-1:0]      left_gene,
  input  logic                      left_valid,
  input  spui_chain_t               chain_in,
  output spui_chain_t               chain_out,
  output logic signed [WORTH_W-1:0] worth,
  output logic [GENE_BITS-1:0]      gene,
  output logic                      valid,
  output logic                      lt,
  output logic                      is_rank,
  output logic                      dup
);

  logic eq;
  logic match;

  // Chain: first active cell not better than the candidate takes it.
  always_comb begin
    is_rank         = active && !lt && !chain_in.seen;
    chain_out.seen  = chain_in.seen || is_rank;
    chain_out.run   = (is_rank || chain_in.run) && eq && active;
    dup             = chain_out.run && match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worth <= '0;
      gene  <= '0;
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cmp_en) begin
        lt    <= valid && (worth < cand_worth);
        eq    <= valid && (worth == cand_worth);
        match <= valid && (worth == cand_worth) && (worth_only || gene == cand_gene);
      end
      if (upd_en) begin
        if (is_rank) begin
          worth <= cand_worth;
          gene  <= cand_gene;
          valid <= 1'b1;
        end else if (chain_in.seen && active) begin
          // shift down one place from the neighbor above
          worth <= left_worth;
          gene  <= left_gene;
          valid <= left_valid;
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for sorted_pool_unique_insert_top: directed rows, then random phases.
// Depends on spui_pkg and the spui_cmd_if / spui_res_if channels from the RTL.
module tb_top import spui_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH      = 64;
  localparam int GENE_BITS       = 64;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_ITEMS     = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int END_CYCLES      = 20;
  localparam int PRESSURE_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int MAX_REPORTS     = 10;

  localparam logic signed [WORTH_W-1:0] WORTH_MIN = 32'sh8000_0000;
  localparam logic signed [WORTH_W-1:0] WORTH_MAX = 32'sh7FFF_FFFF;
  localparam logic [GENE_PORT_W-1:0] GENE_MASK = {GENE_PORT_W{1'b1}} >> (GENE_PORT_W - GENE_BITS);
  localparam logic [GENE_PORT_W-1:0] GENE_FIVES = 64'h5555_5555_5555_5555;
  localparam logic [GENE_PORT_W-1:0] GENE_TENS  = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic [OUTCOME_W-1:0]      outcome;
    logic [RANK_W-1:0]         insert_rank;
    logic signed [WORTH_W-1:0] entry_worth;
    logic [GENE_PORT_W-1:0]    entry_gene;
    logic                      entry_valid;
  } pool_result_t;

  typedef enum logic { ROW_CMD, ROW_CFG } row_op_t;

  typedef struct {
    row_op_t                   op;
    logic                      kind;
    logic signed [WORTH_W-1:0] worth;
    logic [GENE_PORT_W-1:0]    gene;
    logic [RIDX_W-1:0]         ridx;
    logic [CFG_INDEX_W-1:0]    reg_index;
    logic [CFG_DATA_W-1:0]     reg_data;
    bit                        known;
    pool_result_t              known_res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  spui_cmd_if cmd_ch ();
  spui_res_if res_ch ();

  sorted_pool_unique_insert_top #(
    .POOL_DEPTH(POOL_DEPTH),
    .GENE_BITS (GENE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the pool and its registers, advanced at every command transfer.
  logic signed [WORTH_W-1:0] pool_worth [POOL_DEPTH];
  logic [GENE_PORT_W-1:0]    pool_gene  [POOL_DEPTH];
  logic                      pool_filled[POOL_DEPTH];
  logic [PSIZE_W-1:0]        active_size_reg = ACTIVE_SIZE_RESET;
  logic                      unique_reg      = 1'b1;
  logic                      worth_only_reg  = 1'b0;

  // Results owed by the block, oldest first.
  pool_result_t predicted_results[$];
  stim_row_t    stim_rows[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  outcome_seen[4];
  bit  idling_on     = 1'b1;
  bit  pressure_go   = 1'b0;
  bit  pressure_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute what the pool answers to one command and advance the shadow state.
  function automatic pool_result_t sorted_pool_predict(
    input logic                      kind,
    input logic signed [WORTH_W-1:0] worth,
    input logic [GENE_PORT_W-1:0]    gene_in,
    input logic [RIDX_W-1:0]         ridx
  );
    pool_result_t r;
    logic [GENE_PORT_W-1:0] gene;
    int n, last, rank, i;
    bit found, run_on, dup;
    r = '0;
    gene = gene_in & GENE_MASK;
    if (kind == KIND_READ) begin
      r.outcome = OUTCOME_READ;
      if (int'(ridx) < POOL_DEPTH) begin
        r.entry_worth = pool_worth[ridx];
        r.entry_gene  = pool_gene[ridx];
        r.entry_valid = pool_filled[ridx];
      end
      return r;
    end
    // Size 0 behaves as 1, anything past the depth as the full depth.
    n = int'(active_size_reg);
    if (n < 1) n = 1;
    if (n > POOL_DEPTH) n = POOL_DEPTH;
    last = n - 1;
    if (pool_filled[last] && pool_worth[last] < worth) begin
      r.outcome = OUTCOME_WORSE;
      return r;
    end
    // First slot that is empty or not better than the candidate.
    rank = last;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && (!pool_filled[i] || !(pool_worth[i] < worth))) begin
        rank = i;
        found = 1'b1;
      end
    end
    // Duplicate scan covers only the run of filled equal-worth slots from rank.
    dup = 1'b0;
    run_on = 1'b1;
    if (unique_reg) begin
      for (i = rank; i < n; i++) begin
        if (!pool_filled[i] || pool_worth[i] != worth) run_on = 1'b0;
        if (run_on && (worth_only_reg || pool_gene[i] == gene)) dup = 1'b1;
      end
    end
    if (dup) begin
      r.outcome = OUTCOME_DUPLICATE;
      return r;
    end
    for (i = last; i > rank; i--) begin
      pool_worth[i]  = pool_worth[i-1];
      pool_gene[i]   = pool_gene[i-1];
      pool_filled[i] = pool_filled[i-1];
    end
    pool_worth[rank]  = worth;
    pool_gene[rank]   = gene;
    pool_filled[rank] = 1'b1;
    r.outcome     = OUTCOME_INSERTED;
    r.insert_rank = RANK_W'(rank);
    return r;
  endfunction

  function automatic string fmt_result(input pool_result_t r);
    return $sformatf("outcome=%0d rank=%0d worth=%08h gene=%016h valid=%0b",
                     r.outcome, r.insert_rank, r.entry_worth, r.entry_gene, r.entry_valid);
  endfunction

  function automatic void add_cmd(input logic kind, input logic signed [WORTH_W-1:0] worth,
                                  input logic [GENE_PORT_W-1:0] gene,
                                  input logic [RIDX_W-1:0] ridx);
    stim_row_t row;
    row = '{op: ROW_CMD, kind: kind, worth: worth, gene: gene, ridx: ridx,
            reg_index: REG_ACTIVE_SIZE, reg_data: '0, known: 1'b0, known_res: '0};
    stim_rows.push_back(row);
  endfunction

  // Same as add_cmd, but with the answer typed in by hand.
  function automatic void add_known(input logic kind, input logic signed [WORTH_W-1:0] worth,
                                    input logic [GENE_PORT_W-1:0] gene,
                                    input logic [RIDX_W-1:0] ridx,
                                    input logic [OUTCOME_W-1:0] outcome,
                                    input logic [RANK_W-1:0] rank,
                                    input logic signed [WORTH_W-1:0] e_worth,
                                    input logic [GENE_PORT_W-1:0] e_gene,
                                    input logic e_valid);
    add_cmd(kind, worth, gene, ridx);
    stim_rows[$].known     = 1'b1;
    stim_rows[$].known_res = '{outcome, rank, e_worth, e_gene, e_valid};
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{op: ROW_CFG, kind: KIND_INSERT, worth: '0, gene: '0, ridx: '0,
            reg_index: idx, reg_data: data, known: 1'b0, known_res: '0};
    stim_rows.push_back(row);
  endfunction

  // Offer one command, hold it until the transfer, then record what it must produce.
  task automatic send_cmd(input logic kind, input logic signed [WORTH_W-1:0] worth,
                          input logic [GENE_PORT_W-1:0] gene, input logic [RIDX_W-1:0] ridx,
                          input bit known, input pool_result_t known_res);
    pool_result_t p;
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= kind;
    cmd_ch.new_worth  <= worth;
    cmd_ch.gene_bits  <= gene;
    cmd_ch.read_index <= ridx;
    do @(posedge clk); while (!cmd_ch.ready);
    p = sorted_pool_predict(kind, worth, gene, ridx);
    predicted_results.push_back(known ? known_res : p);
    items_sent++;
  endtask

  // Let the pool go idle, then write one register and mirror it in the shadow copy.
  task automatic drain_and_write(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    cmd_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACTIVE_SIZE:        active_size_reg = data[PSIZE_W-1:0];
      REG_UNIQUE_MODE:        unique_reg      = data[0];
      REG_COMPARE_WORTH_ONLY: worth_only_reg  = data[0];
      default: ;
    endcase
  endtask

  // Result side: random stall bursts, plus one long hold-off to back the pool up.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        hold_left = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 4);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer with the oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    pool_result_t want, got;
    bit bad;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.outcome, res_ch.insert_rank, res_ch.entry_worth,
              res_ch.entry_gene, res_ch.entry_valid};
      outcome_seen[got.outcome]++;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: result with nothing pending: %s", fmt_result(got));
      end else begin
        want = predicted_results.pop_front();
        bad = (got.outcome !== want.outcome) || (got.insert_rank !== want.insert_rank) ||
              (got.entry_worth !== want.entry_worth) || (got.entry_gene !== want.entry_gene) ||
              (got.entry_valid !== want.entry_valid);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("tb_top: mismatch at cycle %0d", cycle_count);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic                      kind;
    logic signed [WORTH_W-1:0] w;
    logic [GENE_PORT_W-1:0]    g;
    logic [RIDX_W-1:0]         ridx;
    logic [CFG_DATA_W-1:0]     psize;
    int j, mode, errors;

    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_worth[i]  = '0;
      pool_gene[i]   = '0;
      pool_filled[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) outcome_seen[i] = 0;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ACTIVE_SIZE;
    cfg_data          <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.kind       <= KIND_INSERT;
    cmd_ch.new_worth  <= '0;
    cmd_ch.gene_bits  <= '0;
    cmd_ch.read_index <= '0;

    // Directed rows. Reset state: 64 active slots, unique mode, gene compare.
    // Empty pool reads back as all zero.
    add_known(KIND_READ, 0, 0, 0, OUTCOME_READ, 0, 0, 0, 1'b0);
    add_known(KIND_READ, 0, 0, 63, OUTCOME_READ, 0, 0, 0, 1'b0);
    add_known(KIND_INSERT, 0, 0, 0, OUTCOME_INSERTED, 0, 0, 0, 1'b0);
    // Same worth and gene: duplicate.
    add_known(KIND_INSERT, 0, 0, 0, OUTCOME_DUPLICATE, 0, 0, 0, 1'b0);
    // Same worth, other gene: goes ahead of the stored equal entry.
    add_known(KIND_INSERT, 0, '1, 0, OUTCOME_INSERTED, 0, 0, 0, 1'b0);
    add_known(KIND_INSERT, WORTH_MIN, GENE_FIVES, 0, OUTCOME_INSERTED, 0, 0, 0, 1'b0);
    add_known(KIND_INSERT, WORTH_MAX, GENE_TENS, 0, OUTCOME_INSERTED, 3, 0, 0, 1'b0);
    add_known(KIND_READ, 0, 0, 0, OUTCOME_READ, 0, WORTH_MIN, GENE_FIVES, 1'b1);
    add_known(KIND_READ, 0, 0, 3, OUTCOME_READ, 0, WORTH_MAX, GENE_TENS, 1'b1);
    add_known(KIND_INSERT, WORTH_MAX, GENE_TENS, 0, OUTCOME_DUPLICATE, 0, 0, 0, 1'b0);
    add_cmd(KIND_INSERT, -1, 1, 0);
    add_cmd(KIND_READ, 0, 0, 2);
    // Shrink to four active slots: the worst active entry now has worth 0.
    add_cfg(REG_ACTIVE_SIZE, 4);
    add_known(KIND_INSERT, WORTH_MAX, 0, 0, OUTCOME_WORSE, 0, 0, 0, 1'b0);
    add_cmd(KIND_INSERT, 1, 9, 0);
    add_cmd(KIND_INSERT, 0, 0, 0);
    add_cmd(KIND_INSERT, -1, 2, 0);
    // Size zero acts as a single slot.
    add_cfg(REG_ACTIVE_SIZE, 0);
    add_cmd(KIND_INSERT, WORTH_MIN, GENE_FIVES, 0);
    add_cmd(KIND_INSERT, WORTH_MIN, 7, 0);
    add_cmd(KIND_READ, 0, 0, 4);
    // Oversized setting clamps to the full depth; then insert duplicates freely.
    add_cfg(REG_ACTIVE_SIZE, 127);
    add_cfg(REG_UNIQUE_MODE, 0);
    add_cmd(KIND_INSERT, 0, 0, 0);
    add_cmd(KIND_INSERT, 0, 0, 0);
    // Worth-only compare: any equal worth is a duplicate.
    add_cfg(REG_UNIQUE_MODE, 1);
    add_cfg(REG_COMPARE_WORTH_ONLY, 1);
    add_cmd(KIND_INSERT, 0, 64'h123, 0);
    add_cmd(KIND_INSERT, WORTH_MAX, 0, 0);
    add_cmd(KIND_READ, 0, 0, 63);
    add_cfg(REG_COMPARE_WORTH_ONLY, 0);
    add_cfg(REG_ACTIVE_SIZE, 64);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      if (stim_rows[r].op == ROW_CFG)
        drain_and_write(stim_rows[r].reg_index, stim_rows[r].reg_data);
      else
        send_cmd(stim_rows[r].kind, stim_rows[r].worth, stim_rows[r].gene,
                 stim_rows[r].ridx, stim_rows[r].known, stim_rows[r].known_res);
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0, 4:    psize = CFG_DATA_W'(64);
        1:       psize = CFG_DATA_W'(1);
        2:       psize = CFG_DATA_W'(2);
        3:       psize = CFG_DATA_W'($urandom_range(1, 8));
        5:       psize = CFG_DATA_W'(0);
        6:       psize = CFG_DATA_W'(127);
        default: psize = CFG_DATA_W'($urandom_range(0, 127));
      endcase
      drain_and_write(REG_ACTIVE_SIZE, psize);
      drain_and_write(REG_UNIQUE_MODE,
                      CFG_DATA_W'((phase == 0) ? 1 : $urandom_range(0, 1)));
      drain_and_write(REG_COMPARE_WORTH_ONLY,
                      CFG_DATA_W'((phase == 0) ? 0 : $urandom_range(0, 1)));
      if (phase == 4) pressure_go = 1'b1;
      // Run the final phase flat out on both sides.
      if (phase == RANDOM_PHASES - 1) idling_on = 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_INSERT;
        ridx = RIDX_W'($urandom_range(0, POOL_DEPTH - 1));
        g = ($urandom_range(0, 4) < 3) ? 64'($urandom_range(0, 3)) : {$urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          // Narrow worth range: plenty of ties and duplicates.
          w = $signed($urandom_range(0, 7)) - 4;
        end else if (mode < 8) begin
          w = $urandom;
        end else if (mode == 8) begin
          case ($urandom_range(0, 3))
            0:       w = WORTH_MIN;
            1:       w = WORTH_MAX;
            2:       w = -1;
            default: w = 0;
          endcase
        end else begin
          // Echo a stored entry to hit the duplicate scan.
          j = $urandom_range(0, POOL_DEPTH - 1);
          w = pool_worth[j];
          if ($urandom_range(0, 1)) g = pool_gene[j];
        end
        send_cmd(kind, w, g, ridx, 1'b0, '0);
      end
    end

    cmd_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    errors = mismatches + predicted_results.size();
    $display("tb_top: %0d commands over %0d random phases, %0d mismatches",
             items_sent, RANDOM_PHASES, mismatches);
    $display("tb_top: results seen: %0d inserted, %0d worse, %0d duplicate, %0d reads",
             outcome_seen[OUTCOME_INSERTED], outcome_seen[OUTCOME_WORSE],
             outcome_seen[OUTCOME_DUPLICATE], outcome_seen[OUTCOME_READ]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spui_pkg.sv
rtl/spui_if.sv
rtl/spui_cell.sv
rtl/sorted_pool_unique_insert_top.sv
verif/tb_top.sv
